// ----- src/lgts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lgts_pkg;

  localparam int TRK_COUNT = 5;
  localparam int TRK_OWN = 0;
  localparam int TRK_LF = 1;
  localparam int TRK_LR = 2;
  localparam int TRK_RF = 3;
  localparam int TRK_RR = 4;
  localparam logic [18:0] OWN_LIMIT = 19'd25600;
  localparam logic [18:0] SIDE_LIMIT = 19'd256000;
  localparam logic [16:0] SPEED_NONE = 17'h1FFFF;
  localparam int LANE_WIDTH = 1024;
  localparam int HOR_W = 6;
  localparam int DATA_W = 112;
  localparam int RES_W = 184;

  // One classified vehicle handed from front to back.
  typedef struct packed {
    logic signed [15:0] d;
    logic        [31:0] sq;
    logic        [23:0] s;
    logic        [1:0]  lane;
    logic        [7:0]  hor;
    logic        [24:0] ego;
    logic               last;
  } lgts_item_t;

endpackage
`default_nettype wire

// ----- src/lane_gap_target_selector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Lane gap target selector.
// Input stream: one tracked vehicle per request on in_tdata, with in_tlast
// marking the final vehicle of a frame. Output stream: one request per frame
// with the gap and speed of the nearest vehicle ahead in the own lane and
// ahead and behind in the left and right lanes; -1 in both fields means none.
// cfg_we writes the step time in 1/65536 s.
// The front squares the two velocity components one after the other and
// places the result in a two-entry queue. The back then runs a bit-serial
// square root, two multiplier steps for the projection and one tracker
// update, and takes the next vehicle only once that update is done; the
// square root is the longest of these steps.
// The frame result appears in the cycle after the last vehicle's update and
// is held until taken; while it waits the back takes no new vehicle, the
// front still fills its queue.
// Synchronous reset clears the trackers, the queue and loads step time 1311.
module lane_gap_target_selector
  import lgts_pkg::*;
#(
  parameter int LANE_COUNT = 3,
  parameter int MAX_HORIZON = 63
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_wdata,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // lateral_offset, velocity_x, velocity_y, position_along, ego_lane,
  // horizon_steps, ego_future_position, zero fill
  input  wire logic [DATA_W-1:0]   in_tdata,
  input  wire logic                in_tlast,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // own_front_gap, own_front_speed, left_front_gap, left_front_speed,
  // left_rear_gap, left_rear_speed, right_front_gap, right_front_speed,
  // right_rear_gap, right_rear_speed, zero fill
  output logic [RES_W-1:0]         out_tdata
);

  logic [15:0] step_r;
  logic        q_valid, q_ready;
  lgts_item_t  q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) step_r <= 16'd1311;
    else if (cfg_we) step_r <= cfg_wdata;
  end

  lgts_front #(.MAX_HORIZON(MAX_HORIZON)) u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  lgts_back #(.LANE_COUNT(LANE_COUNT)) u_back (
    .clk(clk), .rst_n(rst_n), .step_time(step_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_noaccept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !q_ready)
    else $error("back took a vehicle while a result waits");
`endif

endmodule
`default_nettype wire

// ----- src/lgts_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lgts_front
  import lgts_pkg::*;
#(
  parameter int MAX_HORIZON = 63
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [DATA_W-1:0]   in_tdata,
  input  wire logic                in_tlast,
  output logic                     q_valid,
  input  wire logic                q_ready,
  output lgts_item_t               q_item
);

  // Two-entry queue; the square of the speed is formed with one multiplier
  // pass per component, in states F_SQX and F_SQY.
  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SQX  = 3'b010,
    F_SQY  = 3'b100
  } f_state_t;

  f_state_t   st_r, st_nxt;
  lgts_item_t cur_r;
  logic signed [15:0] vx_r, vy_r;
  lgts_item_t q_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  logic signed [15:0] mul_op;
  logic [31:0] mul_res;
  logic [7:0]  hor_sat;
  logic        push;
  lgts_item_t q_wr_item;

  assign in_tready = (st_r == F_IDLE) && (cnt_r != 2'd2);
  assign mul_op = (st_r == F_SQX) ? vx_r : vy_r;
  assign mul_res = 32'(mul_op * mul_op);
  assign hor_sat = (32'(in_tdata[79:74]) > 32'(MAX_HORIZON)) ? 8'(MAX_HORIZON)
                 : 8'(in_tdata[79:74]);
  assign push = (st_r == F_SQY);

  always_comb begin
    q_wr_item = cur_r;
    q_wr_item.sq = cur_r.sq + mul_res;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      F_IDLE: if (in_tvalid && in_tready) st_nxt = F_SQX;
      F_SQX:  st_nxt = F_SQY;
      F_SQY:  st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_valid && q_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cur_r.d <= in_tdata[15:0];
      vx_r <= in_tdata[31:16];
      vy_r <= in_tdata[47:32];
      cur_r.s <= in_tdata[71:48];
      cur_r.lane <= in_tdata[73:72];
      cur_r.hor <= hor_sat;
      cur_r.ego <= in_tdata[104:80];
      cur_r.last <= in_tlast;
      cur_r.sq <= '0;
    end
    if (st_r == F_SQX) cur_r.sq <= mul_res;
    if (push) q_r[wp_r] <= q_wr_item;
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_item = q_r[rp_r];

endmodule
`default_nettype wire

// ----- src/lgts_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lgts_sqrt
  import lgts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] x,
  output logic             done,
  output logic [16:0]      root
);

  // Digit-by-digit root, one result bit per cycle, then round to nearest.
  // The partial root is scaled by the current bit weight, so it needs the
  // full operand width until the last step.
  logic [32:0] rem_r;
  logic [32:0] r_r;
  logic [32:0] bit_r;
  logic        busy_r;
  logic [32:0] trial;

  assign trial = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == '0) begin
        busy_r <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  logic [32:0] rb;
  assign rb = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 33'(x);
      r_r <= '0;
      bit_r <= 33'h1_0000_0000 >> 2;
    end else if (busy_r) begin
      if (bit_r != '0) begin
        if (trial >= rb) begin
          rem_r <= trial - rb;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
    end
  end

  assign root = r_r[16:0] + 17'(rem_r > r_r);

endmodule
`default_nettype wire

// ----- src/lgts_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lgts_back
  import lgts_pkg::*;
#(
  parameter int LANE_COUNT = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [15:0]       step_time,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire lgts_item_t        q_item,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [RES_W-1:0]       out_tdata
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_ROOT = 5'b00010,
    B_MUL1 = 5'b00100,
    B_MUL2 = 5'b01000,
    B_UPD  = 5'b10000
  } b_state_t;

  b_state_t   st_r, st_nxt;
  lgts_item_t it_r;
  logic [16:0] spd_r;
  logic [32:0] p1_r;
  logic [40:0] p2_r;
  logic [18:0] gap_r [TRK_COUNT];
  logic [16:0] tspd_r [TRK_COUNT];
  logic [TRK_COUNT-1:0] fnd_r;
  logic        sq_start, sq_done;
  logic [16:0] sq_root;
  logic [25:0] fut;
  logic signed [19:0] d_e;
  logic signed [19:0] lo_own;
  logic in_own, in_l, in_r;
  logic ahead, behind;
  logic [25:0] dfront, dback;
  logic [TRK_COUNT-1:0] hit;
  logic [25:0] cand [TRK_COUNT];

  function automatic logic signed [19:0] q_d_ext(input logic signed [15:0] v);
    return 20'(v);
  endfunction

  // The root starts on the same edge that loads it_r, so it reads the queue.
  lgts_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .x(q_item.sq),
    .done(sq_done), .root(sq_root)
  );

  assign q_ready = (st_r == B_IDLE) && !out_tvalid;
  assign sq_start = (st_r == B_IDLE) && q_valid && q_ready;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: if (sq_start) st_nxt = B_ROOT;
      B_ROOT: if (sq_done) st_nxt = B_MUL1;
      B_MUL1: st_nxt = B_MUL2;
      B_MUL2: st_nxt = B_UPD;
      B_UPD:  st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  // Lane bands (1024*k, 1024*(k+1)) open at both ends.
  assign d_e = 20'(q_d_ext(it_r.d));
  assign lo_own = $signed({8'd0, it_r.lane, 10'd0});
  assign in_own = (d_e > lo_own) && (d_e < lo_own + 20'sd1024);
  assign in_l = (it_r.lane != 2'd0) && (d_e > lo_own - 20'sd1024) && (d_e < lo_own);
  assign in_r = (32'(it_r.lane) + 1 < LANE_COUNT) && (d_e > lo_own + 20'sd1024)
             && (d_e < lo_own + 20'sd2048);

  assign fut = 26'(it_r.s) + 26'((p2_r + 41'd32768) >> 16);
  assign ahead = fut > 26'(it_r.ego);
  assign behind = fut < 26'(it_r.ego);
  assign dfront = fut - 26'(it_r.ego);
  assign dback = 26'(it_r.ego) - fut;

  always_comb begin
    hit[TRK_OWN] = in_own && ahead;
    hit[TRK_LF] = in_l && ahead;
    hit[TRK_LR] = in_l && behind;
    hit[TRK_RF] = in_r && ahead;
    hit[TRK_RR] = in_r && behind;
    cand[TRK_OWN] = dfront;
    cand[TRK_LF] = dfront;
    cand[TRK_LR] = dback;
    cand[TRK_RF] = dfront;
    cand[TRK_RR] = dback;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      out_tvalid <= 1'b0;
      fnd_r <= '0;
      for (int i = 0; i < TRK_COUNT; i++) begin
        gap_r[i] <= (i == TRK_OWN) ? OWN_LIMIT : SIDE_LIMIT;
        tspd_r[i] <= SPEED_NONE;
      end
    end else begin
      st_r <= st_nxt;
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      if (st_r == B_UPD) begin
        for (int i = 0; i < TRK_COUNT; i++) begin
          if (it_r.last) begin
            gap_r[i] <= (i == TRK_OWN) ? OWN_LIMIT : SIDE_LIMIT;
            tspd_r[i] <= SPEED_NONE;
            fnd_r[i] <= 1'b0;
          end else if (hit[i] && cand[i] < 26'(gap_r[i])) begin
            gap_r[i] <= 19'(cand[i]);
            tspd_r[i] <= spd_r;
            fnd_r[i] <= 1'b1;
          end
        end
        if (it_r.last) out_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sq_start) it_r <= q_item;
    if (st_r == B_ROOT && sq_done) spd_r <= sq_root;
    if (st_r == B_MUL1) p1_r <= 33'(spd_r) * 33'(step_time);
    if (st_r == B_MUL2) p2_r <= 41'(p1_r) * 41'(it_r.hor);
    if (st_r == B_UPD && it_r.last) begin
      logic [18:0] g [TRK_COUNT];
      logic [16:0] v [TRK_COUNT];
      logic        f;
      for (int i = 0; i < TRK_COUNT; i++) begin
        f = fnd_r[i];
        g[i] = gap_r[i];
        v[i] = tspd_r[i];
        if (hit[i] && cand[i] < 26'(gap_r[i])) begin
          f = 1'b1;
          g[i] = 19'(cand[i]);
          v[i] = spd_r;
        end
        if (!f) begin
          g[i] = '1;
          v[i] = SPEED_NONE;
        end
      end
      out_tdata <= {7'b0, v[TRK_RR], g[TRK_RR], v[TRK_RF], g[TRK_RF],
                    v[TRK_LR], g[TRK_LR], v[TRK_LF], g[TRK_LF],
                    v[TRK_OWN], g[TRK_OWN][15:0]};
    end
  end

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import lgts_pkg::*;

  // One vehicle request as it travels on the input stream.
  typedef struct {
    logic signed [15:0] lat;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [23:0]        s_pos;
    logic [1:0]         lane;
    logic [5:0]         hor;
    logic [24:0]        ego_s;
    logic               last;
    logic               is_cfg;   // marks a step time write instead of a vehicle
    logic [15:0]        cfg_val;
  } vehicle_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // lateral_offset, velocity_x, velocity_y, position_along, ego_lane,
  // horizon_steps, ego_future_position, zero fill
  logic [DATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // own_front_gap, own_front_speed, left_front_gap, left_front_speed,
  // left_rear_gap, left_rear_speed, right_front_gap, right_front_speed,
  // right_rear_gap, right_rear_speed, zero fill
  logic [RES_W-1:0] out_tdata;

  lane_gap_target_selector dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  vehicle_t pending_q[$];
  logic [RES_W-1:0] frame_expect_q[$];
  int errors = 0;
  bit quiet = 0;         // no idling in the last part of the run
  int hold_cycles = 0;   // a long receiver hold-off, counted by the monitor
  bit pause_req = 0;     // the driver waits here until all frames are back

  // Predictor state: step time and the five nearest-vehicle trackers.
  logic [15:0] pred_step;
  logic [18:0] trk_gap[TRK_COUNT];
  logic [16:0] trk_speed[TRK_COUNT];
  bit          trk_found[TRK_COUNT];

  function automatic void clear_trk();
    for (int i = 0; i < TRK_COUNT; i++) begin
      trk_gap[i] = (i == TRK_OWN) ? OWN_LIMIT : SIDE_LIMIT;
      trk_speed[i] = SPEED_NONE;
      trk_found[i] = 0;
    end
  endfunction

  function automatic void queue_vehicle(vehicle_t v);
    pending_q = {pending_q, v};
  endfunction

  function automatic string field_name(int k);
    case (k)
      0: return "own_front_gap";
      1: return "own_front_speed";
      2: return "left_front_gap";
      3: return "left_front_speed";
      4: return "left_rear_gap";
      5: return "left_rear_speed";
      6: return "right_front_gap";
      7: return "right_front_speed";
      8: return "right_rear_gap";
      default: return "right_rear_speed";
    endcase
  endfunction

  // Integer square root rounded to nearest.
  function automatic logic [16:0] rounded_speed(logic [32:0] sq);
    logic [33:0] r;
    r = 0;
    for (int b = 16; b >= 0; b--)
      if ((r | (34'd1 << b)) * (r | (34'd1 << b)) <= sq) r = r | (34'd1 << b);
    // Round up when sq exceeds r*r + r, i.e. (r + 1/2)^2 < sq + 1/4.
    if (sq - r * r > r) r = r + 1;
    return r[16:0];
  endfunction

  function automatic void offer(int t, logic [63:0] gap, logic [16:0] spd);
    if (gap < trk_gap[t]) begin
      trk_gap[t] = gap[18:0];
      trk_speed[t] = spd;
      trk_found[t] = 1;
    end
  endfunction

  function automatic bit in_band(int d, int k);
    return d > 1024 * k && d < 1024 * (k + 1);
  endfunction

  // Work out the frame result (if any) for one accepted vehicle.
  function automatic void predict_vehicle(vehicle_t v);
    int d, lane;
    logic [32:0] sq;
    logic [16:0] spd;
    logic [63:0] fut, ego;
    logic [RES_W-1:0] res;
    int pos;
    d = v.lat;
    lane = v.lane;
    sq = 33'(v.vx * v.vx) + 33'(v.vy * v.vy);
    spd = rounded_speed(sq);
    fut = 64'(v.s_pos) + ((64'(spd) * 64'(pred_step) * 64'(v.hor) + 64'd32768) >> 16);
    ego = 64'(v.ego_s);
    if (in_band(d, lane) && fut > ego) offer(TRK_OWN, fut - ego, spd);
    if (lane > 0 && in_band(d, lane - 1)) begin
      if (fut > ego) offer(TRK_LF, fut - ego, spd);
      if (fut < ego) offer(TRK_LR, ego - fut, spd);
    end
    if (lane + 1 < 3 && in_band(d, lane + 1)) begin
      if (fut > ego) offer(TRK_RF, fut - ego, spd);
      if (fut < ego) offer(TRK_RR, ego - fut, spd);
    end
    if (!v.last) return;
    res = '0;
    pos = 0;
    for (int i = 0; i < TRK_COUNT; i++) begin
      int gw;
      gw = (i == TRK_OWN) ? 16 : 19;
      for (int b = 0; b < gw; b++) res[pos + b] = trk_found[i] ? trk_gap[i][b] : 1'b1;
      pos += gw;
      for (int b = 0; b < 17; b++) res[pos + b] = trk_found[i] ? trk_speed[i][b] : 1'b1;
      pos += 17;
    end
    frame_expect_q = {frame_expect_q, res};
    clear_trk();
  endfunction

  // Driver: one request per handshake, with random bursts of idle cycles.
  int gap_left = 0;
  bit cfg_wait = 0;
  int settle = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      vehicle_t nx;
      bit take;
      take = !in_tvalid || in_tready;
      cfg_we <= 1'b0;
      if (in_tvalid && in_tready) predict_vehicle(pending_q.pop_front());
      if (take) begin
        if (pending_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (pending_q[0].is_cfg) begin
          // Write only once the block is idle and has drained.
          in_tvalid <= 1'b0;
          if (frame_expect_q.size() != 0 || (in_tvalid && in_tready)) begin
            settle = 0;
          end else if (settle < 40) begin
            settle++;
          end else begin
            nx = pending_q.pop_front();
            cfg_we <= 1'b1;
            cfg_wdata <= nx.cfg_val;
            pred_step = nx.cfg_val;
            settle = 0;
          end
        end else if (pause_req) begin
          in_tvalid <= 1'b0;
          if (frame_expect_q.size() == 0 && !(in_tvalid && in_tready)) pause_req = 0;
        end else if (!quiet && gap_left == 0 && $urandom_range(0, 7) == 0) begin
          in_tvalid <= 1'b0;
          gap_left = $urandom_range(0, 10);
        end else if (gap_left > 0) begin
          in_tvalid <= 1'b0;
          gap_left--;
        end else begin
          nx = pending_q[0];
          in_tvalid <= 1'b1;
          in_tdata <= {nx.ego_s, nx.hor, nx.lane, nx.s_pos, nx.vy, nx.vx, nx.lat};
          in_tlast <= nx.last;
        end
      end
    end
  end

  // Monitor: checks every frame result and stalls the receiver at random.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (frame_expect_q.size() == 0) begin
          $error("frame result with none expected: %h", out_tdata);
          errors++;
        end else begin
          logic [RES_W-1:0] e;
          int pos;
          e = frame_expect_q.pop_front();
          pos = 0;
          for (int i = 0; i < TRK_COUNT; i++) begin
            int gw;
            gw = (i == TRK_OWN) ? 16 : 19;
            if ((e >> pos) % (1 << gw) != (out_tdata >> pos) % (1 << gw)) begin
              $error("%s: expected %0d, actual %0d", field_name(2 * i),
                     (e >> pos) % (1 << gw), (out_tdata >> pos) % (1 << gw));
              errors++;
            end
            pos += gw;
            if ((e >> pos) % (1 << 17) != (out_tdata >> pos) % (1 << 17)) begin
              $error("%s: expected %0d, actual %0d", field_name(2 * i + 1),
                     (e >> pos) % (1 << 17), (out_tdata >> pos) % (1 << 17));
              errors++;
            end
            pos += 17;
          end
          if (e[RES_W-1:177] != out_tdata[RES_W-1:177]) begin
            $error("zero fill: expected %h, actual %h", e[RES_W-1:177],
                   out_tdata[RES_W-1:177]);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic vehicle_t mk(int lat, int vx, int vy, int s, int lane,
                                  int hor, int ego, bit last);
    vehicle_t v;
    v.lat = lat; v.vx = vx; v.vy = vy; v.s_pos = s; v.lane = lane;
    v.hor = hor; v.ego_s = ego; v.last = last; v.is_cfg = 0; v.cfg_val = 0;
    return v;
  endfunction

  function automatic void push_cfg(int val);
    vehicle_t v;
    v = mk(0, 0, 0, 0, 0, 0, 0, 0);
    v.is_cfg = 1;
    v.cfg_val = val;
    queue_vehicle(v);
  endfunction

  // Random vehicle, mostly near the ego and inside the lanes of interest.
  function automatic vehicle_t rand_vehicle(int lane, int ego, bit last);
    int lat, s;
    if ($urandom_range(0, 9) == 0) begin
      lat = $signed(16'($urandom));
      s = $urandom_range(0, 24'hFFFFFF);
    end else begin
      lat = $urandom_range(0, 3071);
      if ($urandom_range(0, 5) == 0) lat = 1024 * $urandom_range(0, 3);
      s = ego - 40000 + $urandom_range(0, 80000);
      if (s < 0) s = 0;
      if (s > 24'hFFFFFF) s = 24'hFFFFFF;
    end
    return mk(lat, $signed(16'($urandom)), $signed(16'($urandom)) >>> $urandom_range(0, 8),
              s, lane, $urandom_range(0, 63), ego, last);
  endfunction

  initial begin
    int lane, ego, n;
    pred_step = 16'd1311;
    clear_trk();
    // Directed: field extremes, band edges, ties, equal position, all lanes.
    queue_vehicle(mk(512, 0, 0, 1000, 0, 0, 0, 0));        // own ahead
    queue_vehicle(mk(512, 0, 0, 1000, 0, 0, 0, 0));        // tie, first wins
    queue_vehicle(mk(1024, 100, 0, 500, 0, 5, 0, 0));      // on band edge
    queue_vehicle(mk(1500, -32768, -32768, 0, 0, 63, 0, 0));
    queue_vehicle(mk(1500, 32767, 32767, 24'hFFFFFF, 0, 63, 25'h1FFFFFF, 1));
    queue_vehicle(mk(-32768, 0, 0, 0, 3, 0, 0, 0));        // ego lane 3
    queue_vehicle(mk(2500, 3, 4, 5000, 3, 10, 5000, 0));   // left of lane 3
    queue_vehicle(mk(32767, 0, 0, 0, 3, 0, 0, 1));
    queue_vehicle(mk(1500, 0, 0, 3000, 1, 0, 3000, 0));    // equal position
    queue_vehicle(mk(500, 256, 0, 2000, 1, 20, 30000, 0)); // left rear
    queue_vehicle(mk(2500, 0, 256, 90000, 1, 20, 30000, 0));
    queue_vehicle(mk(2500, 0, 1, 10, 1, 1, 30000, 0));     // right rear
    queue_vehicle(mk(1500, 0, 0, 30000 + 25600, 1, 0, 30000, 1)); // at limit
    queue_vehicle(mk(2500, 0, 0, 100, 2, 0, 0, 1));
    queue_vehicle(mk(-1, 1, 1, 1, 0, 1, 1, 1));
    push_cfg(0);
    queue_vehicle(mk(1500, 32767, 0, 100, 1, 63, 100, 1));
    push_cfg(65535);
    queue_vehicle(mk(1500, 32767, 0, 100, 1, 63, 100, 1));
    push_cfg(1);
    queue_vehicle(mk(1500, 32767, 0, 100, 1, 63, 100, 1));
    push_cfg(1311);
    // Random frames of 1 to 24 vehicles.
    n = 0;
    while (n < 1900) begin
      int len;
      len = $urandom_range(1, 24);
      lane = $urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2);
      ego = $urandom_range(0, 25'h1FFFFFF);
      if ($urandom_range(0, 2) != 0) ego = $urandom_range(0, 24'hFFFFFF);
      for (int i = 0; i < len; i++)
        queue_vehicle(rand_vehicle(lane, ego, i == len - 1));
      n += len;
      if (n > 600 && n - len <= 600) push_cfg($urandom_range(1, 65535));
      if (n > 1200 && n - len <= 1200) push_cfg(1311);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // Long receiver hold-off so the block fills up and stalls its input.
    wait (pending_q.size() < 1500);
    @(posedge clk);
    hold_cycles = 600;
    wait (pending_q.size() < 1000);
    @(posedge clk);
    pause_req = 1;
    wait (pending_q.size() < 300);
    quiet = 1;
    wait (pending_q.size() == 0 && frame_expect_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && frame_expect_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
